@@ rtl/cba_pkg.sv @@
// Shared codes and types for the chained block allocator.
package cba_pkg;

    localparam int NODES       = 64;
    localparam int BLOCK_BYTES = 512;
    localparam int NAME_BYTES  = 8;

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_EXISTS    = 3'd2;
    localparam logic [2:0] ST_NO_SPACE  = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam logic [6:0] END_LINK = 7'd127;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture input word, clear counters
        logic scan_clr;   // reset scan index
        logic scan_step;  // advance scan index
        logic cnt_free;   // count a free node at the scan index
        logic set_start;  // capture scan index as chain start
        logic alloc;      // write node at scan index as next chain block
        logic link_prev;  // write link of previous block to scan index
        logic end_prev;   // terminate chain at previous block
        logic walk_load;  // set walk cursor to start
        logic walk_step;  // free/report node at cursor, follow link
        logic rd_issue;   // issue memory read at cursor
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic name_empty;
        logic scan_done;   // scan index reached effective limit
        logic match;       // node at scan index is the start of the name
        logic is_free;     // node at scan index is free
        logic enough;      // free count reached need
        logic need_done;   // all needed blocks written
        logic cur_valid;   // walk cursor below limit and step budget left
        logic next_end;    // link read ends chain or step budget is spent
    } t_sts;

endpackage

@@ rtl/cba_datapath.sv @@
// Node table storage, scan and walk datapath for the chained block allocator.
module cba_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [6:0]      i_cfg_nodes,
    input  logic [1:0]      i_operation,
    input  logic [63:0]     i_file_name,
    input  logic [15:0]     i_file_length,
    input  cba_pkg::t_cmd   i_cmd,
    output cba_pkg::t_sts   o_sts,
    output logic [5:0]      o_start,
    output logic [5:0]      o_cur,
    output logic [9:0]      o_fill,
    output logic [6:0]      o_count,
    output logic [1:0]      o_op
);
    import cba_pkg::*;

    localparam int IW  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW  = $clog2(NODES + 1);
    localparam int BW  = $clog2(BLOCK_BYTES + 1);
    localparam int SH  = $clog2(BLOCK_BYTES);

    logic [NODES-1:0]  r_used;
    logic              mem_start [NODES];
    logic [63:0]       mem_name  [NODES];
    logic [BW-1:0]     mem_fill  [NODES];
    logic [6:0]        mem_link  [NODES];

    logic [63:0]  r_name;
    logic [1:0]   r_op;
    logic [16:0]  r_need;
    logic [15:0]  r_rem;
    logic [CW:0]  r_scan;
    logic [CW-1:0] r_free;
    logic [CW-1:0] r_done;
    logic [IW-1:0] r_start;
    logic [IW-1:0] r_prev;
    logic [6:0]   r_cur;
    logic [CW:0]  r_steps;
    logic [6:0]   r_cnt;
    logic         r_rd_start;
    logic [63:0]  r_rd_name;
    logic [6:0]   r_rd_link;
    logic [BW-1:0] r_rd_fill;

    logic [6:0]   lim;
    logic [63:0]  clean;
    logic         stop;
    logic [IW-1:0] scan_ix;
    logic [IW-1:0] cur_ix;
    logic [BW-1:0] fill_now;

    assign lim = (i_cfg_nodes > 7'(NODES)) ? 7'(NODES) : i_cfg_nodes;

    always_comb begin
        clean = '0;
        stop  = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (b < NAME_BYTES && !stop && i_file_name[8*b +: 8] != 8'd0) begin
                clean[8*b +: 8] = i_file_name[8*b +: 8];
            end else begin
                stop = 1'b1;
            end
        end
    end

    assign scan_ix  = r_scan[IW-1:0];
    assign cur_ix   = r_cur[IW-1:0];
    assign fill_now = (r_rem > 16'(BLOCK_BYTES)) ? BW'(BLOCK_BYTES) : BW'(r_rem);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_name <= clean;
            r_op   <= i_operation;
            r_rem  <= i_file_length;
            r_need <= (i_file_length == 16'd0) ? 17'd1
                    : 17'(({1'b0, i_file_length} + 17'(BLOCK_BYTES - 1)) >> SH);
        end
        if (i_cmd.alloc) begin
            r_rem <= r_rem - 16'(fill_now);
        end
        if (i_cmd.scan_clr) begin
            r_scan <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan <= r_scan + 1'b1;
        end
        if (i_cmd.set_start) begin
            r_start <= scan_ix;
        end
        if (i_cmd.alloc) begin
            r_prev <= scan_ix;
        end
        if (i_cmd.walk_load) begin
            r_cur <= 7'(r_start);
        end else if (i_cmd.walk_step) begin
            r_cur <= r_rd_link;
        end
        if (i_cmd.rd_issue) begin
            r_rd_link <= mem_link[cur_ix];
            r_rd_fill <= mem_fill[cur_ix];
        end
        r_rd_start <= mem_start[scan_ix];
        r_rd_name  <= mem_name[scan_ix];
        if (i_cmd.alloc) begin
            mem_start[scan_ix] <= (r_done == '0);
            mem_name[scan_ix]  <= r_name;
            mem_fill[scan_ix]  <= fill_now;
        end
        if (i_cmd.link_prev) begin
            mem_link[r_prev] <= r_scan[6:0];
        end else if (i_cmd.end_prev) begin
            mem_link[r_prev] <= END_LINK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_free  <= '0;
            r_done  <= '0;
            r_steps <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_free  <= '0;
                r_done  <= '0;
                r_steps <= '0;
                r_cnt   <= '0;
            end
            if (i_cmd.cnt_free) begin
                r_free <= r_free + 1'b1;
            end
            if (i_cmd.alloc) begin
                r_used[scan_ix] <= 1'b1;
                r_done <= r_done + 1'b1;
            end
            if (i_cmd.walk_step) begin
                if (r_op == OP_REMOVE) begin
                    r_used[cur_ix] <= 1'b0;
                end
                r_steps <= r_steps + 1'b1;
                r_cnt   <= r_cnt + 1'b1;
            end
        end
    end

    assign o_sts.name_empty = (r_name == 64'd0);
    assign o_sts.scan_done  = (r_scan >= (CW+1)'(lim));
    assign o_sts.match      = r_used[scan_ix] && r_rd_start && (r_rd_name == r_name);
    assign o_sts.is_free    = !r_used[scan_ix];
    assign o_sts.enough     = (17'(r_free) >= r_need);
    assign o_sts.need_done  = (17'(r_done) >= r_need);
    assign o_sts.cur_valid  = (r_cur < lim) && (r_steps < (CW+1)'(NODES));
    assign o_sts.next_end   = (r_rd_link >= lim) || ((r_steps + 1'b1) >= (CW+1)'(NODES));

    assign o_start = 6'(r_start);
    assign o_cur   = 6'(r_cur);
    assign o_fill  = 10'(r_rd_fill);
    assign o_count = (r_op == OP_CREATE) ? 7'(r_need) : r_cnt;
    assign o_op    = r_op;
endmodule

@@ rtl/cba_ctrl.sv @@
// Sequencing state machine for the chained block allocator.
module cba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_operation,
    input  logic [1:0]     i_op,
    input  cba_pkg::t_sts  i_sts,
    output cba_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_strobe,
    output logic [2:0]     o_status,
    output logic           o_last,
    output logic           o_rpt_node,
    output logic           o_rpt_fill,
    output logic           o_rpt_cnt
);
    import cba_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_FIND_R  = 4'd2;  // memory read in flight
    localparam logic [3:0] S_FIND    = 4'd3;
    localparam logic [3:0] S_COUNT   = 4'd4;
    localparam logic [3:0] S_ALLOC   = 4'd5;
    localparam logic [3:0] S_W_RD    = 4'd6;
    localparam logic [3:0] S_W_WAIT  = 4'd7;
    localparam logic [3:0] S_W_STEP  = 4'd8;
    localparam logic [3:0] S_FINISH  = 4'd9;
    localparam logic [3:0] S_ALLOC_R = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_found, n_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_found    = r_found;
        o_cmd      = '0;
        o_strobe   = 1'b0;
        o_status   = ST_OK;
        o_last     = 1'b1;
        o_rpt_node = 1'b0;
        o_rpt_fill = 1'b0;
        o_rpt_cnt  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_operation != OP_UNUSED) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_found        = 1'b0;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.name_empty) begin
                    o_strobe = 1'b1;
                    o_status = (i_op == OP_CREATE) ? ST_EMPTY : ST_NOT_FOUND;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_FIND_R;
                end
            end
            S_FIND_R: begin
                n_state = S_FIND;
            end
            S_FIND: begin
                // nodes at or above the limit never match
                if (i_sts.scan_done) begin
                    n_state = S_FINISH;
                end else if (i_sts.match) begin
                    o_cmd.set_start = 1'b1;
                    n_found = 1'b1;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state = S_FIND_R;
                end
            end
            S_FINISH: begin
                o_cmd.scan_clr = 1'b1;
                if (i_op == OP_CREATE) begin
                    if (r_found) begin
                        o_strobe = 1'b1;
                        o_status = ST_EXISTS;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_COUNT;
                    end
                end else if (!r_found) begin
                    o_strobe = 1'b1;
                    o_status = ST_NOT_FOUND;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.walk_load = 1'b1;
                    n_state = S_W_RD;
                end
            end
            S_COUNT: begin
                if (i_sts.enough) begin
                    o_cmd.scan_clr = 1'b1;
                    n_found = 1'b0;
                    n_state = S_ALLOC;
                end else if (i_sts.scan_done) begin
                    o_strobe = 1'b1;
                    o_status = ST_NO_SPACE;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.cnt_free  = i_sts.is_free;
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_ALLOC: begin
                if (i_sts.need_done) begin
                    o_cmd.end_prev = 1'b1;
                    o_strobe   = 1'b1;
                    o_rpt_node = 1'b1;
                    o_rpt_cnt  = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    if (i_sts.is_free) begin
                        o_cmd.alloc     = 1'b1;
                        o_cmd.set_start = !r_found;
                        o_cmd.link_prev = r_found;
                        n_found         = 1'b1;
                    end
                    o_cmd.scan_step = 1'b1;
                    n_state = S_ALLOC_R;
                end
            end
            S_ALLOC_R: begin
                n_state = S_ALLOC;
            end
            S_W_RD: begin
                if (i_sts.cur_valid) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state = S_W_WAIT;
                end else begin
                    // remove: summary word after the walk ends
                    o_strobe   = (i_op == OP_REMOVE);
                    o_rpt_node = 1'b1;
                    o_rpt_cnt  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_W_WAIT: begin
                n_state = S_W_STEP;
            end
            S_W_STEP: begin
                if (i_op == OP_READ) begin
                    o_strobe   = 1'b1;
                    o_rpt_node = 1'b1;
                    o_rpt_fill = 1'b1;
                    o_last     = i_sts.next_end;
                    if (i_sts.next_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_W_RD;
                    end
                end else begin
                    n_state = S_W_RD;
                end
                o_cmd.walk_step = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

@@ rtl/cba_seq.sv @@
// Result word stage: registers each formed result onto the output ports.
module cba_seq (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_strobe,
    input  logic [2:0]  i_status,
    input  logic        i_last,
    input  logic        i_rpt_node,
    input  logic        i_rpt_fill,
    input  logic        i_rpt_cnt,
    input  logic [5:0]  i_start_node,
    input  logic [5:0]  i_cur,
    input  logic [9:0]  i_fill,
    input  logic [6:0]  i_count,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [5:0]  o_node,
    output logic [9:0]  o_byte_count,
    output logic [6:0]  o_node_count,
    output logic        o_last
);
    logic       r_strobe, r_last;
    logic [2:0] r_status;
    logic [5:0] r_node;
    logic [9:0] r_fill;
    logic [6:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_strobe;
        end
        r_status <= i_status;
        r_last   <= i_last;
        r_node   <= i_rpt_node ? (i_rpt_fill ? i_cur : i_start_node) : 6'd0;
        r_fill   <= i_rpt_fill ? i_fill : 10'd0;
        r_count  <= i_rpt_cnt ? i_count : 7'd0;
    end

    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_node       = r_node;
    assign o_byte_count = r_fill;
    assign o_node_count = r_count;
    assign o_last       = r_last;
endmodule

@@ rtl/chained_block_allocator_top.sv @@
// Top level of the chained block allocator: controller, datapath, result register.
//
// channel | direction | handshake                | word
// command | in        | start and not busy       | i_operation, i_file_name, i_file_length
// result  | out       | o_strobe, one cycle each | o_status, o_node, o_byte_count,
//         |           |                          | o_node_count, o_last
// config  | in        | i_cfg_we                 | i_cfg_data (nodes_in_use)
//
// A lookup is a name check, read and compare per node scanned up to the match, and a
// turn-round. Create then counts free nodes (one a cycle) and writes the chain,
// allocate and wait per node scanned; remove and read walk it through the table
// memory read port, issue, wait and step per node. Each result leaves through the
// output register in the cycle after it is formed; busy stays high for that cycle.
// Reset clears the in-use flags at once; no clearing pass. The receiver cannot stall.
module chained_block_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_file_name,
    input  logic [15:0] i_file_length,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [5:0]  o_node,
    output logic [9:0]  o_byte_count,
    output logic [6:0]  o_node_count,
    output logic        o_last
);
    import cba_pkg::*;

    t_cmd       cmd;
    t_sts       sts;
    logic [6:0] r_cfg;
    logic [5:0] dp_start, dp_cur;
    logic [9:0] dp_fill;
    logic [6:0] dp_count;
    logic [1:0] dp_op;
    logic       seq_strobe, seq_last, rpt_node, rpt_fill, rpt_cnt, seq_busy;
    logic [2:0] seq_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 7'd64;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    cba_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_nodes(r_cfg),
        .i_operation(i_operation), .i_file_name(i_file_name),
        .i_file_length(i_file_length), .i_cmd(cmd), .o_sts(sts),
        .o_start(dp_start), .o_cur(dp_cur), .o_fill(dp_fill),
        .o_count(dp_count), .o_op(dp_op)
    );

    cba_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start & ~busy),
        .i_operation(i_operation), .i_op(dp_op), .i_sts(sts), .o_cmd(cmd),
        .o_busy(seq_busy), .o_strobe(seq_strobe), .o_status(seq_status),
        .o_last(seq_last), .o_rpt_node(rpt_node), .o_rpt_fill(rpt_fill),
        .o_rpt_cnt(rpt_cnt)
    );

    cba_seq u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_strobe(seq_strobe),
        .i_status(seq_status), .i_last(seq_last), .i_rpt_node(rpt_node),
        .i_rpt_fill(rpt_fill), .i_rpt_cnt(rpt_cnt), .i_start_node(dp_start),
        .i_cur(dp_cur), .i_fill(dp_fill), .i_count(dp_count),
        .o_strobe(o_strobe), .o_status(o_status), .o_node(o_node),
        .o_byte_count(o_byte_count), .o_node_count(o_node_count), .o_last(o_last)
    );

    // hold off new words until the last result has left the register
    assign busy = seq_busy | o_strobe;
endmodule
